[hdl/dwpd_pkg.sv]
// ----------------------------------------------------------------------------
// dwpd_pkg - shared types and constants
// Constants, register indexes and the divider request and response types for the
// dual wheel PD speed controller.
// ----------------------------------------------------------------------------
package dwpd_pkg;

	localparam int unsigned PWM_PERIOD = 1000;
	localparam int unsigned STALL_INTERVAL = 100;
	localparam int unsigned STEP_SCALE = 100;
	localparam int unsigned DIV_W = 48;

	localparam logic [0:0] REG_PROP_GAIN  = 1'b0;
	localparam logic [0:0] REG_DERIV_GAIN = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;   // magnitude
		logic [16:0]      den;   // magnitude, nonzero
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

[hdl/dual_wheel_pd_speed_control_top.sv]
// ----------------------------------------------------------------------------
// dual_wheel_pd_speed_control_top - two wheel PD speed controller
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | s_axis_tvalid/tready   | targets, speeds, steps, dirs
// m_axis   | out | m_axis_tvalid/tready   | four duty values, straight flag
// cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// Each tick runs, per wheel, up to three 48 bit divisions on the shared
// one-bit-per-cycle divider (step interval, error term, change term), the
// interval division only for a step delta of 1..100. Reset clears the state
// and sets the gains to 10 and 5; request, term and output data are not reset.
// The result waits in an output register; the next request is taken while
// it waits, and cfg is taken only when idle.
// ----------------------------------------------------------------------------
module dual_wheel_pd_speed_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// left_target, right_target, left_speed, right_speed, left_steps,
	// right_steps, left_dir, right_dir
	input  logic [135:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// left_fwd, left_back, right_fwd, right_back duty, straight_mode, pad
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dwpd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INT, S_WAIT_I, S_DIV_E, S_WAIT_E, S_DIV_C, S_WAIT_C, S_SUM, S_STR,
		S_OUT
	} state_t;

	state_t       state_q;
	logic         wheel_q;
	logic [15:0]  kp_q, kd_q;
	logic [9:0]   pow_q [2];
	logic signed [16:0] perr_q [2];
	logic [31:0]  psteps_q [2];
	logic [31:0]  base_q [2];
	logic         str_q;
	logic [15:0]  tgt_q [2], spd_q [2];
	logic [31:0]  stp_q [2];
	logic [1:0]   dir_q;
	logic [6:0]   ival_q;
	logic signed [17:0] eterm_q;
	logic signed [47:0] cterm_q;
	logic         neg_q;
	logic [47:0]  out_q;
	logic         ovalid_q;

	div_req_t dreq;
	div_rsp_t drsp;
	dwpd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [16:0] err;
	logic signed [17:0] chg;
	logic signed [35:0] chg_kd;
	logic [31:0]  delta;
	logic         int_div;
	logic [16:0]  kp_eff;
	logic signed [49:0] psum;
	logic [31:0]  idiff;
	logic signed [48:0] adj;
	logic signed [49:0] lsum, rsum;

	function automatic logic [9:0] sat(input logic signed [49:0] v);
		if (v < 0) return '0;
		if (v > 50'(PWM_PERIOD)) return 10'(PWM_PERIOD);
		return v[9:0];
	endfunction

	assign err    = $signed({1'b0, tgt_q[wheel_q]}) - $signed({1'b0, spd_q[wheel_q]});
	assign chg    = 18'(err) - 18'(perr_q[wheel_q]);
	assign chg_kd = chg * $signed({1'b0, kd_q});
	assign delta  = stp_q[wheel_q] - psteps_q[wheel_q];
	assign int_div = (delta != 32'd0) && (delta <= 32'(STEP_SCALE));
	assign kp_eff = (kp_q == 16'd0) ? 17'd1 : {1'b0, kp_q};
	assign psum   = 50'($signed({1'b0, pow_q[wheel_q]})) + 50'(eterm_q) + 50'(cterm_q);
	assign idiff  = (stp_q[1] - base_q[1]) - (stp_q[0] - base_q[0]);
	assign adj    = $signed(idiff) * $signed({1'b0, kp_q});
	assign lsum   = 50'($signed({1'b0, pow_q[0]})) + 50'(adj);
	assign rsum   = 50'($signed({1'b0, pow_q[1]})) - 50'(adj);

	logic signed [47:0] qs;
	assign qs = neg_q ? -$signed(drsp.quo) : $signed(drsp.quo);

	always_comb begin
		dreq = '0;
		dreq.den = kp_eff;
		if (state_q == S_INT) begin
			dreq.start = int_div;
			dreq.num = 48'(STEP_SCALE);
			dreq.den = {10'd0, delta[6:0]};
		end else if (state_q == S_DIV_E) begin
			dreq.start = 1'b1;
			dreq.num = 48'(err < 0 ? -err : err);
		end else if (state_q == S_DIV_C) begin
			dreq.start = 1'b1;
			dreq.num = 48'(chg_kd < 0 ? -chg_kd : chg_kd);
			dreq.den = {10'd0, ival_q};
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wheel_q  <= 1'b0;
			kp_q     <= 16'd10;
			kd_q     <= 16'd5;
			pow_q    <= '{default: '0};
			perr_q   <= '{default: '0};
			psteps_q <= '{default: '0};
			base_q   <= '{default: '0};
			str_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PROP_GAIN) kp_q <= cfg_data;
				else kd_q <= cfg_data;
			end
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					tgt_q[0] <= s_axis_tdata[15:0];
					tgt_q[1] <= s_axis_tdata[31:16];
					spd_q[0] <= s_axis_tdata[47:32];
					spd_q[1] <= s_axis_tdata[63:48];
					stp_q[0] <= s_axis_tdata[95:64];
					stp_q[1] <= s_axis_tdata[127:96];
					dir_q    <= s_axis_tdata[129:128];
					wheel_q  <= 1'b0;
					state_q  <= S_INT;
				end
				S_INT: begin
					// interval: divide 100 by the step delta only when it is 1..100
					if (int_div) begin
						state_q <= S_WAIT_I;
					end else begin
						ival_q  <= (delta == 32'd0) ? 7'(STALL_INTERVAL) : 7'd1;
						state_q <= S_DIV_E;
					end
				end
				S_WAIT_I: if (drsp.done) begin
					ival_q  <= drsp.quo[6:0];
					state_q <= S_DIV_E;
				end
				S_DIV_E: begin
					neg_q   <= err < 0;
					state_q <= S_WAIT_E;
				end
				S_WAIT_E: if (drsp.done) begin
					eterm_q <= 18'(qs);
					state_q <= S_DIV_C;
				end
				S_DIV_C: begin
					neg_q   <= chg_kd < 0;
					state_q <= S_WAIT_C;
				end
				S_WAIT_C: if (drsp.done) begin
					cterm_q <= qs;
					state_q <= S_SUM;
				end
				S_SUM: begin
					pow_q[wheel_q]    <= sat(psum);
					perr_q[wheel_q]   <= err;
					psteps_q[wheel_q] <= stp_q[wheel_q];
					wheel_q <= 1'b1;
					state_q <= wheel_q ? S_STR : S_INT;
				end
				S_STR: begin
					if (tgt_q[0] == tgt_q[1]) begin
						if (!str_q) begin
							str_q     <= 1'b1;
							base_q[0] <= stp_q[0];
							base_q[1] <= stp_q[1];
						end else begin
							pow_q[0] <= sat(lsum);
							pow_q[1] <= sat(rsum);
						end
					end else begin
						str_q <= 1'b0;
					end
					state_q <= S_OUT;
				end
				// hold until the previous result has been taken
				S_OUT: if (!ovalid_q) begin
					out_q <= {7'd0, str_q,
						dir_q[1] ? pow_q[1] : 10'd0, dir_q[1] ? 10'd0 : pow_q[1],
						dir_q[0] ? pow_q[0] : 10'd0, dir_q[0] ? 10'd0 : pow_q[0]};
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/dwpd_div.sv]
// ----------------------------------------------------------------------------
// dwpd_div - shared unsigned divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwpd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dwpd_pkg::div_req_t req,
	output dwpd_pkg::div_rsp_t rsp
);
	import dwpd_pkg::*;

	localparam int unsigned CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [17:0]      rem_q;
	logic [16:0]      den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [17:0]      trial;
	logic [18:0]      diff;

	assign trial = {rem_q[16:0], quo_q[DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
				quo_q  <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
			end else if (busy_q) begin
				if (!diff[18]) begin
					rem_q <= diff[17:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
